### design/dscg_pkg.sv
// Package for the decaying sine click generator.
// Holds register indexes, reset values, parameter defaults and sine polynomial coefficients.
// No dependencies.
package dscg_pkg;

	localparam int SINE_TABLE_BITS_DEF   = 10;
	localparam int MAX_CLICK_SAMPLES_DEF = 65535;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CLICK_SAMPLES = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_GAIN   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DECAY_FACTOR  = 2'd3;

	localparam logic [22:0] PHASE_STEP_RST    = 23'd218870;
	localparam logic [15:0] CLICK_SAMPLES_RST = 16'd2205;
	localparam logic [15:0] VOLUME_GAIN_RST   = 16'd4096;
	localparam logic [23:0] DECAY_FACTOR_RST  = 24'd16762005;

	localparam logic [23:0] ENV_FULL   = 24'hFFFFFF;
	localparam logic [15:0] SIN_ONE    = 16'd32768;
	localparam logic [23:0] SCALE_MULT = 24'd875;
	localparam logic [60:0] PROD_LIMIT = 61'd1 << 51;

	localparam longint Q30_ONE = 64'sd1 << 30;
	localparam longint POLY_C1 = 64'sd1686629713;
	localparam longint POLY_C3 = -64'sd693598669;
	localparam longint POLY_C5 = 64'sd85569306;
	localparam longint POLY_C7 = -64'sd5026995;
	localparam longint POLY_C9 = 64'sd172272;

endpackage

### design/decaying_sine_click_generator_top.sv
// Decaying sine click generator top level: sequencer around one shared 28x24 multiplier.
// Depends on dscg_pkg for register indexes, reset values and sine coefficients.
//
//  channel | signals                              | transaction
//  --------+--------------------------------------+-------------------------------
//  s       | s_tvalid s_tready s_tdata            | one sample tick, bit 0 trigger
//  m       | m_tvalid m_tready m_tdata m_tuser    | one sample, active, last
//          | m_tlast                              |
//  cfg     | cfg_valid cfg_ready cfg_index        | one register write
//          | cfg_data                             |
//
// An active tick runs from the accept cycle through one sine ROM read and eight steps,
// six of which pass through the shared multiplier, to the update, which loads the
// result register. An idle tick goes from the accept cycle straight to the update.
// The result register frees the sequencer while a sample waits; a stalled output holds
// the sequencer in its last step. Reset clears the sequencer, click state and output
// valid and loads the register reset values; cfg is always ready.
module decaying_sine_click_generator_top #(
	parameter int SINE_TABLE_BITS   = dscg_pkg::SINE_TABLE_BITS_DEF,
	parameter int MAX_CLICK_SAMPLES = dscg_pkg::MAX_CLICK_SAMPLES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [0] trigger, [7:1] zero
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata,   // [15:0] sample
	output logic                             m_tuser,   // [0] active
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dscg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dscg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int TBL_SIZE = 1 << SINE_TABLE_BITS;
	localparam int CNT_W    = $clog2(MAX_CLICK_SAMPLES + 1);

	typedef logic [15:0] rom_t [TBL_SIZE];

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_ROM  = 11'b000_0000_0010,
		S_M1   = 11'b000_0000_0100,
		S_M2   = 11'b000_0000_1000,
		S_M3   = 11'b000_0001_0000,
		S_M4   = 11'b000_0010_0000,
		S_M5   = 11'b000_0100_0000,
		S_M6   = 11'b000_1000_0000,
		S_M7   = 11'b001_0000_0000,
		S_M8   = 11'b010_0000_0000,
		S_FIN  = 11'b100_0000_0000
	} state_t;

	function automatic rom_t build_rom();
		rom_t   r;
		longint x;
		longint x2;
		longint p;
		longint s;
		longint q;
		for (int i = 0; i < TBL_SIZE; i++) begin
			x  = longint'(i) << (30 - SINE_TABLE_BITS);
			x2 = (x * x) >>> 30;
			p  = dscg_pkg::POLY_C9;
			p  = dscg_pkg::POLY_C7 + (p * x2) / dscg_pkg::Q30_ONE;
			p  = dscg_pkg::POLY_C5 + (p * x2) / dscg_pkg::Q30_ONE;
			p  = dscg_pkg::POLY_C3 + (p * x2) / dscg_pkg::Q30_ONE;
			p  = dscg_pkg::POLY_C1 + (p * x2) / dscg_pkg::Q30_ONE;
			s  = (x * p) / dscg_pkg::Q30_ONE;
			if (s < 0) begin
				s = 0;
			end
			q = (s + 16384) >>> 15;
			if (q > 32768) begin
				q = 32768;
			end
			r[i] = 16'(q);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	state_t state_q;

	logic [22:0] phase_step_q;
	logic [15:0] click_samples_q;
	logic [15:0] volume_gain_q;
	logic [23:0] decay_factor_q;

	logic [23:0]      phase_q;
	logic [23:0]      env_q;
	logic [CNT_W-1:0] cnt_q;
	logic             active_q;
	logic             busy_q;

	logic [15:0] rom_q;
	logic        one_q;
	logic        neg_q;
	logic [51:0] prod_q;
	logic [27:0] hi_q;
	logic [60:0] acc_q;
	logic [51:0] clamp_q;

	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic        m_tuser_q;
	logic        m_tlast_q;

	logic                       in_fire;
	logic                       start;
	logic [CNT_W-1:0]           len;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [SINE_TABLE_BITS-1:0] addr;
	logic [15:0]                mag;
	logic [27:0]                mul_a;
	logic [23:0]                mul_b;
	logic [51:0]                prod;
	logic [60:0]                acc_sum;
	logic                       out_free;
	logic [14:0]                scaled;
	logic [15:0]                sample;
	logic [CNT_W-1:0]           cnt_next;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign m_tlast   = m_tlast_q;

	assign in_fire  = s_tvalid && s_tready;
	assign start    = s_tdata[0] && (phase_step_q != '0) && (click_samples_q != '0);
	assign len      = (32'(click_samples_q) > 32'(MAX_CLICK_SAMPLES)) ?
			CNT_W'(MAX_CLICK_SAMPLES) : CNT_W'(click_samples_q);
	assign idx      = phase_q[21 -: SINE_TABLE_BITS];
	assign addr     = phase_q[22] ? (~idx + SINE_TABLE_BITS'(1)) : idx;
	assign mag      = one_q ? dscg_pkg::SIN_ONE : rom_q;
	assign prod     = 52'(mul_a) * 52'(mul_b);
	assign acc_sum  = acc_q + {prod_q[36:0], 24'b0};
	assign out_free = !m_tvalid_q || m_tready;
	assign scaled   = acc_q[60:46];
	assign sample   = neg_q ? (16'd0 - {1'b0, scaled}) : {1'b0, scaled};
	assign cnt_next = (cnt_q != '0) ? (cnt_q - CNT_W'(1)) : cnt_q;

	always_comb begin
		unique case (state_q)
			S_M1: begin
				mul_a = 28'(mag);
				mul_b = env_q;
			end
			S_M2: begin
				mul_a = 28'(prod_q[23:0]);
				mul_b = 24'(volume_gain_q);
			end
			S_M3: begin
				mul_a = hi_q;
				mul_b = 24'(volume_gain_q);
			end
			S_M4: begin
				mul_a = 28'(env_q);
				mul_b = decay_factor_q;
			end
			S_M6: begin
				mul_a = 28'(clamp_q[23:0]);
				mul_b = dscg_pkg::SCALE_MULT;
			end
			S_M7: begin
				mul_a = clamp_q[51:24];
				mul_b = dscg_pkg::SCALE_MULT;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q    <= dscg_pkg::PHASE_STEP_RST;
			click_samples_q <= dscg_pkg::CLICK_SAMPLES_RST;
			volume_gain_q   <= dscg_pkg::VOLUME_GAIN_RST;
			decay_factor_q  <= dscg_pkg::DECAY_FACTOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dscg_pkg::REG_PHASE_STEP:    phase_step_q    <= cfg_data[22:0];
				dscg_pkg::REG_CLICK_SAMPLES: click_samples_q <= cfg_data[15:0];
				dscg_pkg::REG_VOLUME_GAIN:   volume_gain_q   <= cfg_data[15:0];
				dscg_pkg::REG_DECAY_FACTOR:  decay_factor_q  <= cfg_data[23:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= ((state_q == S_FIN) && out_free) || (m_tvalid_q && !m_tready);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= '0;
			env_q      <= '0;
			cnt_q      <= '0;
			active_q   <= 1'b0;
			busy_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (start) begin
							phase_q  <= '0;
							env_q    <= dscg_pkg::ENV_FULL;
							cnt_q    <= len;
							active_q <= 1'b1;
						end
						busy_q  <= start || active_q;
						state_q <= (start || active_q) ? S_ROM : S_FIN;
					end
				end
				S_ROM: state_q <= S_M1;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= S_M4;
				S_M4:  state_q <= S_M5;
				S_M5: begin
					env_q   <= prod_q[47:24];
					state_q <= S_M6;
				end
				S_M6:  state_q <= S_M7;
				S_M7:  state_q <= S_M8;
				S_M8:  state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						if (busy_q) begin
							phase_q <= phase_q + {1'b0, phase_step_q};
							cnt_q   <= cnt_next;
							if (cnt_next == '0) begin
								active_q <= 1'b0;
							end
						end
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_ROM: begin
				rom_q <= SINE_ROM[addr];
				one_q <= phase_q[22] && (idx == '0);
				neg_q <= phase_q[23];
			end
			S_M1: prod_q <= prod;
			S_M2: begin
				prod_q <= prod;
				hi_q   <= 28'(prod_q[40:24]);
			end
			S_M3: begin
				prod_q <= prod;
				acc_q  <= 61'(prod_q);
			end
			S_M4: begin
				prod_q <= prod;
				acc_q  <= acc_sum;
			end
			S_M5: clamp_q <= (acc_q > dscg_pkg::PROD_LIMIT) ?
					dscg_pkg::PROD_LIMIT[51:0] : acc_q[51:0];
			S_M6: prod_q <= prod;
			S_M7: begin
				prod_q <= prod;
				acc_q  <= 61'(prod_q);
			end
			S_M8: acc_q <= acc_sum;
			S_FIN: begin
				if (out_free) begin
					m_tdata_q <= busy_q ? sample : '0;
					m_tuser_q <= busy_q;
					m_tlast_q <= busy_q && (cnt_next == '0);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_last_in_click: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("last raised outside a click");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("nonzero sample while idle");

	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= 16'sd28000) && ($signed(m_tdata) >= -16'sd28000))
		else $error("sample beyond full scale");

	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> cnt_q != '0)
		else $error("click active with empty count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");
`endif

endmodule

### verif/tb_decaying_sine_click_generator_top.sv
// Self-checking testbench for the decaying sine click generator top level.
// Predicts every sample in a scoreboard class and drives ticks, results and register writes.
// Depends on dscg_pkg and decaying_sine_click_generator_top.
`timescale 1ns / 100ps

module tb_decaying_sine_click_generator_top;

	localparam int     SINE_BITS    = 10;
	localparam int     SINE_ENTRIES = 1 << SINE_BITS;
	localparam longint Q30          = 64'sd1 << 30;
	localparam longint TAYLOR_C1    = 64'sd1686629713;
	localparam longint TAYLOR_C3    = -64'sd693598669;
	localparam longint TAYLOR_C5    = 64'sd85569306;
	localparam longint TAYLOR_C7    = -64'sd5026995;
	localparam longint TAYLOR_C9    = 64'sd172272;
	localparam int     RANDOM_PHASES    = 8;
	localparam int     TICKS_PER_PHASE  = 94;

	typedef struct packed {
		logic [15:0] sample;
		logic        active;
		logic        last;
	} click_result_t;

	class click_scoreboard;
		bit [15:0]     quarter_wave [SINE_ENTRIES];
		logic [22:0]   phase_step;
		logic [15:0]   click_len;
		logic [15:0]   gain;
		logic [23:0]   decay;
		logic [23:0]   phase;
		logic [23:0]   env;
		logic [15:0]   remaining;
		bit            running;
		click_result_t expected_q [$];

		function new();
			longint x, x2, p, s, q;
			for (int i = 0; i < SINE_ENTRIES; i++) begin
				x  = longint'(i) << (30 - SINE_BITS);
				x2 = (x * x) >>> 30;
				p  = TAYLOR_C9;
				p  = TAYLOR_C7 + (p * x2) / Q30;
				p  = TAYLOR_C5 + (p * x2) / Q30;
				p  = TAYLOR_C3 + (p * x2) / Q30;
				p  = TAYLOR_C1 + (p * x2) / Q30;
				s  = (x * p) / Q30;
				if (s < 0)
					s = 0;
				q = (s + 16384) >>> 15;
				if (q > 32768)
					q = 32768;
				quarter_wave[i] = q[15:0];
			end
			phase_step = dscg_pkg::PHASE_STEP_RST;
			click_len  = dscg_pkg::CLICK_SAMPLES_RST;
			gain       = dscg_pkg::VOLUME_GAIN_RST;
			decay      = dscg_pkg::DECAY_FACTOR_RST;
			phase      = '0;
			env        = '0;
			remaining  = '0;
			running    = 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void set_reg(logic [dscg_pkg::CFG_INDEX_W-1:0] idx,
				logic [dscg_pkg::CFG_DATA_W-1:0] value);
			case (idx)
				dscg_pkg::REG_PHASE_STEP:    phase_step = value[22:0];
				dscg_pkg::REG_CLICK_SAMPLES: click_len  = value[15:0];
				dscg_pkg::REG_VOLUME_GAIN:   gain       = value[15:0];
				dscg_pkg::REG_DECAY_FACTOR:  decay      = value[23:0];
				default: ;
			endcase
		endfunction

		function void note_tick(logic trig);
			click_result_t r;
			bit [63:0]     mag;
			bit [63:0]     prod;
			bit [63:0]     scaled;
			logic [1:0]    quad;
			logic [SINE_BITS-1:0] idx;
			r = '0;
			if (trig && phase_step != 0 && click_len != 0) begin
				phase     = '0;
				env       = dscg_pkg::ENV_FULL;
				remaining = click_len;
				running   = 1'b1;
			end
			r.active = running;
			if (running) begin
				quad = phase[23:22];
				idx  = phase[21:22-SINE_BITS];
				if (quad[0])
					mag = (idx == 0) ? 64'd32768 : 64'(quarter_wave[SINE_ENTRIES - int'(idx)]);
				else
					mag = 64'(quarter_wave[idx]);
				prod = mag * 64'(env) * 64'(gain);
				if (prod > (64'd1 << 51))
					prod = 64'd1 << 51;
				scaled   = (prod * 64'd875) >> 46;
				r.sample = quad[1] ? -scaled[15:0] : scaled[15:0];
				env      = 24'((64'(env) * 64'(decay)) >> 24);
				phase    = phase + 24'(phase_step);
				if (remaining != 0)
					remaining--;
				if (remaining == 0) begin
					r.last  = 1'b1;
					running = 1'b0;
				end
			end
			expected_q.push_back(r);
		endfunction

		function string check_sample(logic [15:0] got_sample, logic got_active, logic got_last);
			click_result_t r;
			string         msg;
			if (expected_q.size() == 0)
				return $sformatf(" no tick pending for sample %0d active %b last %b",
					$signed(got_sample), got_active, got_last);
			r   = expected_q.pop_front();
			msg = "";
			if (got_sample !== r.sample)
				msg = {msg, $sformatf(" sample %0d expected %0d", $signed(got_sample),
					$signed(r.sample))};
			if (got_active !== r.active)
				msg = {msg, $sformatf(" active %b expected %b", got_active, r.active)};
			if (got_last !== r.last)
				msg = {msg, $sformatf(" last %b expected %b", got_last, r.last)};
			return msg;
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [7:0]                       s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [15:0]                      m_tdata;
	logic                             m_tuser;
	logic                             m_tlast;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [dscg_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [dscg_pkg::CFG_DATA_W-1:0]  cfg_data;

	click_scoreboard sb = new();
	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int ticks_sent;
	int results_checked;
	int active_samples;
	int clicks_ended;
	int settings_count;

	decaying_sine_click_generator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= 100)
			$display("%0t ns: result %0d mismatch:%s", $time, results_checked, what);
	endtask

	task automatic send_tick(input logic trig);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, trig};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_tick(trig);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [dscg_pkg::CFG_INDEX_W-1:0] idx,
			input logic [dscg_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_reg(idx, value);
		@(negedge clk);
	endtask

	// drain all pending samples, then let the sequencer settle before touching registers
	task automatic program_regs(input logic [22:0] step, input logic [15:0] len,
			input logic [15:0] vol, input logic [23:0] dec);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		write_reg(dscg_pkg::REG_PHASE_STEP, dscg_pkg::CFG_DATA_W'(step));
		write_reg(dscg_pkg::REG_CLICK_SAMPLES, dscg_pkg::CFG_DATA_W'(len));
		write_reg(dscg_pkg::REG_VOLUME_GAIN, dscg_pkg::CFG_DATA_W'(vol));
		write_reg(dscg_pkg::REG_DECAY_FACTOR, dec);
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin : check_results
		string msg;
		if (arst_n && m_tvalid && m_tready) begin
			msg = sb.check_sample(m_tdata, m_tuser, m_tlast);
			results_checked++;
			if (m_tuser)
				active_samples++;
			if (m_tlast)
				clicks_ended++;
			if (msg != "")
				report_mismatch(msg);
		end
	end

	initial begin
		#10ms;
		$display("Timeout with %0d samples still pending", sb.pending());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [22:0] step;
		logic [15:0] len;
		logic [15:0] vol;
		logic [23:0] dec;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = dscg_pkg::REG_PHASE_STEP;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: idle ticks, a click, a restart in the middle of it
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		// largest step, full volume: negative half, three-sample click
		program_regs(23'h7FFFFF, 16'd3, 16'hFFFF, 24'hFFFFFF);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		// zero step drops the trigger
		program_regs(23'd0, 16'd1, 16'd0, 24'd0);
		send_tick(1'b1);
		send_tick(1'b0);
		// zero length drops the trigger
		program_regs(23'h400000, 16'd0, 16'd4096, 24'd0);
		send_tick(1'b1);
		// quarter-wave steps hit every quadrant boundary
		program_regs(23'h400000, 16'd5, 16'd4096, 24'hFFFFFF);
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
		// smallest step, zero decay kills the envelope after one sample
		program_regs(23'd1, 16'd4, 16'hFFFF, 24'd0);
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
			step = (ph == 1) ? 23'h7FFFFF :
				($urandom_range(0, 1) ? 23'($urandom_range(1, 23'h7FFFFF)) :
				23'($urandom_range(1, 40000)));
			len = (ph == 5) ? 16'hFFFF :
				(ph == 6) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 40));
			vol = (ph == 2) ? 16'hFFFF : (ph == 3) ? 16'd0 : 16'($urandom);
			dec = (ph == 4) ? 24'hFFFFFF : (ph == 7) ? 24'd0 :
				(ph == 0) ? 24'($urandom) : 24'($urandom_range(15000000, 24'hFFFFFF));
			program_regs(step, len, vol, dec);
			case (ph % 4)
				1: send_idle_pct = 85;
				2: recv_stall_pct = 85;
				3: begin
					send_idle_pct  = 20;
					recv_stall_pct = 20;
				end
				default: ;
			endcase
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				if (ph == 2 && n == TICKS_PER_PHASE / 2) begin
					s_tvalid <= 1'b0;
					do
						@(negedge clk);
					while (sb.pending() != 0);
				end
				send_tick($urandom_range(0, 11) == 0);
			end
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("Sent %0d ticks under %0d register settings, checked %0d samples",
			ticks_sent, settings_count, results_checked);
		$display("%0d samples belonged to clicks, %0d clicks ran to their end",
			active_samples, clicks_ended);
		if (error_count == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
